@@ rtl/core/cljs_pkg.sv @@
`default_nettype none

package cljs_pkg;

  // Command codes of one input transfer
  typedef enum logic [2:0] {
    OP_ENQUEUE = 3'd0,
    OP_CANCEL  = 3'd1,
    OP_RETRY   = 3'd2,
    OP_START   = 3'd3,
    OP_FINISH  = 3'd4,
    OP_RECOVER = 3'd5
  } cljs_op_e;

  // Result codes
  typedef enum logic [2:0] {
    RES_OK          = 3'd0,
    RES_NOTHING     = 3'd1,
    RES_NOT_FOUND   = 3'd2,
    RES_TERMINAL    = 3'd3,
    RES_NOT_RETRY   = 3'd4,
    RES_BAD_FINAL   = 3'd5,
    RES_TABLE_FULL  = 3'd6,
    RES_QUEUE_FULL  = 3'd7
  } cljs_res_e;

  // Job status codes
  localparam logic [3:0] ST_QUEUED      = 4'd0;
  localparam logic [3:0] ST_DOWNLOADING = 4'd1;
  localparam logic [3:0] ST_MERGING     = 4'd2;
  localparam logic [3:0] ST_CONVERTING  = 4'd3;
  localparam logic [3:0] ST_VALIDATING  = 4'd4;
  localparam logic [3:0] ST_COMPLETED   = 4'd5;
  localparam logic [3:0] ST_FAILED      = 4'd6;
  localparam logic [3:0] ST_CANCELLED   = 4'd7;
  localparam logic [3:0] ST_INTERRUPTED = 4'd8;

  // Job kinds
  localparam logic [1:0] KIND_DOWNLOAD = 2'd0;
  localparam logic [1:0] KIND_CONVERT  = 2'd1;
  localparam logic [1:0] KIND_MERGE    = 2'd2;
  localparam logic [1:0] KIND_VALIDATE = 2'd3;

  localparam logic [1:0] FIN_INVALID = 2'd3;

  // Configuration register indexes
  localparam logic CFG_MAX_DOWNLOADS   = 1'b0;
  localparam logic CFG_MAX_CONVERSIONS = 1'b1;

  localparam int unsigned CfgWidth = 5;

  typedef struct packed {
    logic [2:0] operation;
    logic [1:0] job_kind;
    logic [3:0] job_slot;
    logic [1:0] final_state;
  } cljs_in_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic [3:0]  slot_out;
    logic [3:0]  job_status;
    logic [31:0] event_sequence;
    logic        event_valid;
    logic [4:0]  recovered_count;
  } cljs_out_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_CN_RD,
    S_CN_WR,
    S_SN_RD,
    S_SN_KIND,
    S_SN_CHK,
    S_SH_RD,
    S_SH_WR,
    S_FN_EXEC,
    S_RC_RD,
    S_RC_WR,
    S_DONE
  } cljs_state_e;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      st_raddr_idx;
    logic      kd_raddr_cand;
    logic      cap_cand;
    logic      set_code;
    cljs_res_e code;
    logic      enq;
    logic      cn_mark;
    logic      cn_step;
    logic      cn_end;
    logic      retry;
    logic      sn_found;
    logic      sn_next;
    logic      sh_step;
    logic      sn_commit;
    logic      finish;
    logic      rc_step;
    logic      rc_end;
    logic      publish;
  } cljs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       fin_bad;
    logic       slot_ok;
    logic       jobs_full;
    logic       pend_full;
    logic       st_terminal;
    logic       st_retryable;
    logic       more_fifo;
    logic       more_jobs;
    logic       startable;
    logic       out_free;
  } cljs_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/cljs_ram.sv @@
`default_nettype none

module cljs_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/cljs_ctrl.sv @@
`default_nettype none

module cljs_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire cljs_pkg::cljs_stat_t stat_i,
  output cljs_pkg::cljs_cmd_t      cmd_o
);
  import cljs_pkg::*;

  cljs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.code = RES_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (stat_i.op)
          OP_ENQUEUE: begin
            if (stat_i.jobs_full) begin
              cmd_o.set_code = 1'b1;
              cmd_o.code = RES_TABLE_FULL;
            end else if (stat_i.pend_full) begin
              cmd_o.set_code = 1'b1;
              cmd_o.code = RES_QUEUE_FULL;
            end else begin
              cmd_o.enq = 1'b1;
            end
          end
          OP_CANCEL, OP_RETRY: begin
            if (!stat_i.slot_ok) begin
              cmd_o.set_code = 1'b1;
              cmd_o.code = RES_NOT_FOUND;
            end else begin
              state_d = S_CHECK;
            end
          end
          OP_START: state_d = S_SN_RD;
          OP_FINISH: begin
            if (stat_i.fin_bad) begin
              cmd_o.set_code = 1'b1;
              cmd_o.code = RES_BAD_FINAL;
            end else if (!stat_i.slot_ok) begin
              cmd_o.set_code = 1'b1;
              cmd_o.code = RES_NOT_FOUND;
            end else begin
              state_d = S_FN_EXEC;
            end
          end
          OP_RECOVER: state_d = S_RC_RD;
          default: begin
            cmd_o.set_code = 1'b1;
            cmd_o.code = RES_NOT_FOUND;
          end
        endcase
      end
      // Status of the addressed slot is now readable
      S_CHECK: begin
        state_d = S_DONE;
        if (stat_i.op == OP_CANCEL) begin
          if (stat_i.st_terminal) begin
            cmd_o.set_code = 1'b1;
            cmd_o.code = RES_TERMINAL;
          end else begin
            cmd_o.cn_mark = 1'b1;
            state_d = S_CN_RD;
          end
        end else if (!stat_i.st_retryable) begin
          cmd_o.set_code = 1'b1;
          cmd_o.code = RES_NOT_RETRY;
        end else if (stat_i.pend_full) begin
          cmd_o.set_code = 1'b1;
          cmd_o.code = RES_QUEUE_FULL;
        end else begin
          cmd_o.retry = 1'b1;
        end
      end
      // Cancel: compact the queue, dropping copies of the slot
      S_CN_RD: begin
        if (stat_i.more_fifo) begin
          state_d = S_CN_WR;
        end else begin
          cmd_o.cn_end = 1'b1;
          state_d = S_DONE;
        end
      end
      S_CN_WR: begin
        cmd_o.cn_step = 1'b1;
        state_d = S_CN_RD;
      end
      // Start-next: search the queue in order
      S_SN_RD: begin
        if (stat_i.more_fifo) begin
          state_d = S_SN_KIND;
        end else begin
          cmd_o.set_code = 1'b1;
          cmd_o.code = RES_NOTHING;
          state_d = S_DONE;
        end
      end
      S_SN_KIND: begin
        cmd_o.cap_cand = 1'b1;
        cmd_o.kd_raddr_cand = 1'b1;
        state_d = S_SN_CHK;
      end
      S_SN_CHK: begin
        if (stat_i.startable) begin
          cmd_o.sn_found = 1'b1;
          state_d = S_SH_RD;
        end else begin
          cmd_o.sn_next = 1'b1;
          state_d = S_SN_RD;
        end
      end
      // Close the gap left by the started entry
      S_SH_RD: begin
        if (stat_i.more_fifo) begin
          state_d = S_SH_WR;
        end else begin
          cmd_o.sn_commit = 1'b1;
          state_d = S_DONE;
        end
      end
      S_SH_WR: begin
        cmd_o.sh_step = 1'b1;
        state_d = S_SH_RD;
      end
      S_FN_EXEC: begin
        cmd_o.finish = 1'b1;
        state_d = S_DONE;
      end
      // Recover: walk every used slot
      S_RC_RD: begin
        if (stat_i.more_jobs) begin
          cmd_o.st_raddr_idx = 1'b1;
          state_d = S_RC_WR;
        end else begin
          cmd_o.rc_end = 1'b1;
          state_d = S_DONE;
        end
      end
      S_RC_WR: begin
        cmd_o.rc_step = 1'b1;
        state_d = S_RC_RD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_publish_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> (state_q == S_IDLE))
    else $error("publish did not return to idle");
  a_load_to_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_DECODE))
    else $error("accepted command not decoded");
  a_shift_after_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sh_step |-> $past(state_q) == S_SH_RD)
    else $error("shift step out of sequence");
`endif

endmodule

`default_nettype wire

@@ rtl/core/cljs_dpath.sv @@
`default_nettype none

module cljs_dpath #(
  parameter int unsigned JOB_SLOTS     = 16,
  parameter int unsigned PENDING_DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cljs_pkg::cljs_in_t            in_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [cljs_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  wire cljs_pkg::cljs_cmd_t           cmd_i,
  output cljs_pkg::cljs_stat_t               stat_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output cljs_pkg::cljs_out_t                out_data_o
);
  import cljs_pkg::*;

  localparam int unsigned SW = $clog2(JOB_SLOTS);
  localparam int unsigned PA = $clog2(PENDING_DEPTH);
  localparam int unsigned JW = $clog2(JOB_SLOTS + 1);
  localparam int unsigned PW = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned MaxD = (JOB_SLOTS > PENDING_DEPTH) ? JOB_SLOTS : PENDING_DEPTH;
  localparam int unsigned IW = $clog2(MaxD + 1);
  localparam int unsigned CW = JW + 4 + SW;

  // Captured command
  cljs_in_t in_q;

  // Control state
  logic [JW-1:0]       jobs_used_q;
  logic [PW-1:0]       pend_used_q;
  logic [4:0]          run_dl_q, run_cv_q;
  logic [31:0]         seq_q;
  logic [CfgWidth-1:0] max_dl_q, max_cv_q;
  logic [IW-1:0]       idx_q, wr_q;
  logic [4:0]          rec_q;
  logic                out_valid_q;

  // Working payload
  logic [SW-1:0] cand_q;
  logic [1:0]    kind_cap_q;
  cljs_res_e     res_code_q;
  logic [SW-1:0] res_slot_q;
  logic [3:0]    res_status_q;
  logic [31:0]   res_seq_q;
  logic          res_ev_q;
  logic [4:0]    res_rec_q;
  cljs_out_t     out_q;

  // Memory ports
  logic          st_we, kd_we, ff_we;
  logic [SW-1:0] st_waddr, st_raddr, kd_waddr, kd_raddr;
  logic [3:0]    st_wdata, st_rdata;
  logic [1:0]    kd_rdata;
  logic [PA-1:0] ff_waddr;
  logic [SW-1:0] ff_wdata, ff_rdata;

  logic [SW-1:0] slot_idx;
  logic          st_active, keep, emit;
  logic [3:0]    run_st, fin_st;
  logic [SW-1:0] pend_slot;

  assign slot_idx  = SW'(in_q.job_slot);
  assign st_active = (st_rdata >= ST_DOWNLOADING) && (st_rdata <= ST_VALIDATING);
  assign keep      = (ff_rdata != slot_idx);
  assign fin_st    = ST_COMPLETED + 4'(in_q.final_state);
  assign emit      = cmd_i.enq | cmd_i.cn_end | cmd_i.retry | cmd_i.sn_commit | cmd_i.finish;
  assign pend_slot = cmd_i.enq ? jobs_used_q[SW-1:0] : slot_idx;

  // Running status for the kind of the started job
  always_comb begin
    case (kind_cap_q)
      KIND_DOWNLOAD: run_st = ST_DOWNLOADING;
      KIND_MERGE:    run_st = ST_MERGING;
      KIND_CONVERT:  run_st = ST_CONVERTING;
      default:       run_st = ST_VALIDATING;
    endcase
  end

  // Status flags for the controller
  always_comb begin
    stat_o.op           = in_q.operation;
    stat_o.fin_bad      = (in_q.final_state == FIN_INVALID);
    stat_o.slot_ok      = (CW'(in_q.job_slot) < CW'(jobs_used_q));
    stat_o.jobs_full    = (jobs_used_q == JW'(JOB_SLOTS));
    stat_o.pend_full    = (pend_used_q == PW'(PENDING_DEPTH));
    stat_o.st_terminal  = (st_rdata >= ST_COMPLETED) && (st_rdata <= ST_CANCELLED);
    stat_o.st_retryable = (st_rdata == ST_FAILED) || (st_rdata == ST_CANCELLED) ||
                          (st_rdata == ST_INTERRUPTED);
    stat_o.more_fifo    = (idx_q < IW'(pend_used_q));
    stat_o.more_jobs    = (idx_q < IW'(jobs_used_q));
    stat_o.out_free     = !out_valid_q || !out_stall_i;
    if (CW'(cand_q) >= CW'(jobs_used_q)) begin
      stat_o.startable = 1'b0;
    end else if (kd_rdata == KIND_DOWNLOAD) begin
      stat_o.startable = (run_dl_q < max_dl_q);
    end else if (kd_rdata == KIND_CONVERT || kd_rdata == KIND_MERGE) begin
      stat_o.startable = (run_cv_q < max_cv_q);
    end else begin
      stat_o.startable = 1'b1;
    end
  end

  // Status table write port
  always_comb begin
    st_we    = 1'b1;
    st_waddr = slot_idx;
    st_wdata = ST_QUEUED;
    if (cmd_i.enq) begin
      st_waddr = jobs_used_q[SW-1:0];
    end else if (cmd_i.cn_mark) begin
      st_wdata = ST_CANCELLED;
    end else if (cmd_i.retry) begin
      st_wdata = ST_QUEUED;
    end else if (cmd_i.sn_commit) begin
      st_waddr = cand_q;
      st_wdata = run_st;
    end else if (cmd_i.finish) begin
      st_wdata = fin_st;
    end else if (cmd_i.rc_step && st_active) begin
      st_waddr = idx_q[SW-1:0];
      st_wdata = ST_INTERRUPTED;
    end else begin
      st_we = 1'b0;
    end
  end

  // Queue write port
  always_comb begin
    ff_we    = 1'b1;
    ff_waddr = wr_q[PA-1:0];
    ff_wdata = ff_rdata;
    if (cmd_i.enq || cmd_i.retry) begin
      ff_waddr = pend_used_q[PA-1:0];
      ff_wdata = pend_slot;
    end else if (cmd_i.sh_step || (cmd_i.cn_step && keep)) begin
      ff_wdata = ff_rdata;
    end else begin
      ff_we = 1'b0;
    end
  end

  assign kd_we    = cmd_i.enq;
  assign kd_waddr = jobs_used_q[SW-1:0];
  assign st_raddr = cmd_i.st_raddr_idx ? idx_q[SW-1:0] : slot_idx;
  assign kd_raddr = cmd_i.kd_raddr_cand ? ff_rdata : slot_idx;

  cljs_ram #(.Width(4), .Depth(JOB_SLOTS)) u_status_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  cljs_ram #(.Width(2), .Depth(JOB_SLOTS)) u_kind_ram (
    .clk_i  (clk_i),
    .we_i   (kd_we),
    .waddr_i(kd_waddr),
    .wdata_i(in_q.job_kind),
    .raddr_i(kd_raddr),
    .rdata_o(kd_rdata)
  );

  cljs_ram #(.Width(SW), .Depth(PENDING_DEPTH)) u_fifo_ram (
    .clk_i  (clk_i),
    .we_i   (ff_we),
    .waddr_i(ff_waddr),
    .wdata_i(ff_wdata),
    .raddr_i(idx_q[PA-1:0]),
    .rdata_o(ff_rdata)
  );

  // Counters, limits, scan indexes, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jobs_used_q <= '0;
      pend_used_q <= '0;
      run_dl_q    <= '0;
      run_cv_q    <= '0;
      seq_q       <= '0;
      max_dl_q    <= CfgWidth'(2);
      max_cv_q    <= CfgWidth'(1);
      idx_q       <= '0;
      wr_q        <= '0;
      rec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MAX_DOWNLOADS) max_dl_q <= cfg_wdata_i;
        else max_cv_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        idx_q <= '0;
        wr_q  <= '0;
        rec_q <= '0;
      end
      if (emit) seq_q <= seq_q + 32'd1;
      if (cmd_i.enq) begin
        jobs_used_q <= jobs_used_q + JW'(1);
        pend_used_q <= pend_used_q + PW'(1);
      end
      if (cmd_i.retry) pend_used_q <= pend_used_q + PW'(1);
      if (cmd_i.cn_step) begin
        idx_q <= idx_q + IW'(1);
        if (keep) wr_q <= wr_q + IW'(1);
      end
      if (cmd_i.cn_end) pend_used_q <= PW'(wr_q);
      if (cmd_i.sn_next) idx_q <= idx_q + IW'(1);
      if (cmd_i.sn_found) begin
        wr_q  <= idx_q;
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.sh_step) begin
        wr_q  <= wr_q + IW'(1);
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.sn_commit) begin
        pend_used_q <= pend_used_q - PW'(1);
        if (kind_cap_q == KIND_DOWNLOAD) run_dl_q <= run_dl_q + 5'd1;
        else if (kind_cap_q == KIND_CONVERT || kind_cap_q == KIND_MERGE) begin
          run_cv_q <= run_cv_q + 5'd1;
        end
      end
      if (cmd_i.finish) begin
        if (kd_rdata == KIND_DOWNLOAD && run_dl_q != 5'd0) begin
          run_dl_q <= run_dl_q - 5'd1;
        end else if ((kd_rdata == KIND_CONVERT || kd_rdata == KIND_MERGE) &&
                     run_cv_q != 5'd0) begin
          run_cv_q <= run_cv_q - 5'd1;
        end
      end
      if (cmd_i.rc_step) begin
        idx_q <= idx_q + IW'(1);
        if (st_active) rec_q <= rec_q + 5'd1;
      end
      if (cmd_i.rc_end) begin
        run_dl_q <= '0;
        run_cv_q <= '0;
      end
      if (cmd_i.publish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q         <= in_data_i;
      res_code_q   <= RES_OK;
      res_slot_q   <= '0;
      res_status_q <= ST_QUEUED;
      res_seq_q    <= '0;
      res_ev_q     <= 1'b0;
      res_rec_q    <= '0;
    end
    if (cmd_i.set_code) res_code_q <= cmd_i.code;
    if (cmd_i.cap_cand) cand_q <= ff_rdata;
    if (cmd_i.sn_found) kind_cap_q <= kd_rdata;
    if (emit) begin
      res_seq_q <= seq_q + 32'd1;
      res_ev_q  <= 1'b1;
    end
    if (cmd_i.enq) begin
      res_slot_q   <= jobs_used_q[SW-1:0];
      res_status_q <= ST_QUEUED;
    end
    if (cmd_i.cn_mark) begin
      res_slot_q   <= slot_idx;
      res_status_q <= ST_CANCELLED;
    end
    if (cmd_i.retry) begin
      res_slot_q   <= slot_idx;
      res_status_q <= ST_QUEUED;
    end
    if (cmd_i.sn_commit) begin
      res_slot_q   <= cand_q;
      res_status_q <= run_st;
    end
    if (cmd_i.finish) begin
      res_slot_q   <= slot_idx;
      res_status_q <= fin_st;
    end
    if (cmd_i.rc_end) res_rec_q <= rec_q;
    if (cmd_i.publish) begin
      out_q.result_code     <= res_code_q;
      out_q.slot_out        <= 4'(res_slot_q);
      out_q.job_status      <= res_status_q;
      out_q.event_sequence  <= res_seq_q;
      out_q.event_valid     <= res_ev_q;
      out_q.recovered_count <= res_rec_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_used_q <= PW'(PENDING_DEPTH))
    else $error("pending count beyond depth");
  a_jobs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jobs_used_q <= JW'(JOB_SLOTS))
    else $error("job count beyond table");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");
  a_event_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.event_valid |-> out_q.result_code == RES_OK)
    else $error("event with error code");
`endif

endmodule

`default_nettype wire

@@ rtl/core/class_limited_job_scheduler_core.sv @@
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_data_i  (cljs_in_t)
// out       output     out_valid_o / out_stall_i out_data_o (cljs_out_t)
// cfg       input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One command at a time; in_stall_o is held until its result is published.
// Cancel compacts the pending queue; start-next searches it in order and shifts
// the entries behind the started one up; recover walks every used status slot.
// These scans use the one read port of the pending queue and status memories.
// Asynchronous active-low reset clears counters and reloads the limits;
// memories are not cleared. A held result does not block the next transfer in.

module class_limited_job_scheduler_core #(
  parameter int unsigned JOB_SLOTS     = 16,
  parameter int unsigned PENDING_DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire cljs_pkg::cljs_in_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output cljs_pkg::cljs_out_t                out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [cljs_pkg::CfgWidth-1:0] cfg_wdata_i
);
  import cljs_pkg::*;

  cljs_cmd_t  cmd;
  cljs_stat_t stat;

  // Sequencer
  cljs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Tables, queue and counters
  cljs_dpath #(
    .JOB_SLOTS    (JOB_SLOTS),
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
